/* sv/bfe2m1_pkg.sv */
// Shared constants and widths for the bf16 to E2M1 scaled cast.
`default_nettype none
package bfe2m1_pkg;

  localparam int BF16_W   = 16;
  localparam int SCALE_W  = 8;
  localparam int CODE_W   = 4;
  localparam int OUT_W    = 8;
  localparam int IN_W     = 2 * BF16_W + SCALE_W;

  // Only two elements travel per transaction.
  localparam int CAST_LANES_MAX = 2;
  localparam int LANES_DEF      = 2;

  localparam logic [7:0] BF16_EXP_ALL  = 8'hFF;
  localparam logic [7:0] BF16_MAX_EXP  = 8'hFE;
  localparam logic [6:0] BF16_MANT_MAX = 7'h7F;

  // Quotient exponent window: sh >= 8 saturates, sh < -8 flushes to zero.
  localparam logic signed [9:0] SH_HI  = 10'sd8;
  localparam logic signed [9:0] SH_LO  = -10'sd8;
  localparam logic signed [9:0] SH_OFS = 10'sd5;

  // Decision points between neighboring grid values, in quarters.
  localparam int NUM_MID = 7;
  localparam logic [4:0] MID_Q [NUM_MID] = '{5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd14, 5'd20};

  localparam logic [2:0] IDX_ZERO = 3'd0;
  localparam logic [2:0] IDX_MAX  = 3'd7;

endpackage
`default_nettype wire

/* sv/bf16_to_e2m1_scaled_cast.sv */
// Casts two bf16 elements per transaction to E2M1 codes under a shared block scale.
//
// Input stream: in_tdata carries value_low, value_high and block_scale (an 8-bit
// biased exponent). The scale divides both elements; each quotient rounds to the
// nearest point of {0, .5, 1, 1.5, 2, 3, 4, 6}, ties to even, above 6 saturates.
// Output stream: out_tdata is one byte, high element code in 7:4, low in 3:0;
// a code is the sign in bit 3 and the grid index in 2:0.
// An accepted transaction passes the lane register, then the output register,
// before out_tvalid rises. Throughput: one transaction per cycle while
// out_tready is high.
// Each lane is one decode/compare core; the lanes run in parallel.
// Reset clears both valid flags; no result is pending after reset.
// When the receiver stalls, the output register holds its byte and the lane
// stage can still take one more transaction; after that in_tready drops.
`default_nettype none
module bf16_to_e2m1_scaled_cast
  import bfe2m1_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // value_low[15:0], value_high[31:16], block_scale[39:32]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata   // packed_codes[7:0]
);

  localparam int NCAST = (LANES < CAST_LANES_MAX) ? LANES : CAST_LANES_MAX;

  logic                    in_fire;
  logic                    s1_valid_r;
  logic                    s1_adv;
  logic [NCAST*CODE_W-1:0] codes;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  for (genvar g = 0; g < NCAST; g++) begin : g_lane
    bfe2m1_lane u_lane (
      .clk   (clk),
      .load  (in_fire),
      .bf16  (in_tdata[g*BF16_W +: BF16_W]),
      .scale (in_tdata[2*BF16_W +: SCALE_W]),
      .code  (codes[g*CODE_W +: CODE_W])
    );
  end

  bfe2m1_merge #(
    .NCAST (NCAST)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .codes     (codes),
    .out_ready (out_tready),
    .s1_adv    (s1_adv),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted transaction did not reach the lane stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("stalled lane stage lost its transaction");

  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("lane stage advanced but no result is offered");

  a_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are full and stalled");

endmodule
`default_nettype wire

/* sv/bfe2m1_lane.sv */
// One cast lane: bf16 decode and shift setup, then grid compare and rounding.
`default_nettype none
module bfe2m1_lane
  import bfe2m1_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [BF16_W-1:0]  bf16,
  input  wire logic [SCALE_W-1:0] scale,
  output logic      [CODE_W-1:0]  code
);

  logic              sign_nxt, sign_r;
  logic              zero_nxt, zero_r;
  logic              sat_nxt, sat_r;
  logic [7:0]        sig_nxt, sig_r;
  logic [3:0]        shamt_nxt, shamt_r;
  logic [7:0]        exp_c;
  logic [6:0]        mant_c;
  logic signed [9:0] sh_c;

  always_comb begin
    sign_nxt = bf16[15];
    exp_c    = bf16[14:7];
    mant_c   = bf16[6:0];
    // Inf/NaN clamp to the largest finite magnitude
    if (exp_c == BF16_EXP_ALL) begin
      exp_c  = BF16_MAX_EXP;
      mant_c = BF16_MANT_MAX;
    end
    sh_c      = $signed({2'b00, exp_c}) - $signed({2'b00, scale}) - SH_OFS;
    zero_nxt  = (exp_c == 8'd0) || (sh_c < SH_LO);
    sat_nxt   = (exp_c != 8'd0) && (sh_c >= SH_HI);
    sig_nxt   = {1'b1, mant_c};
    shamt_nxt = sh_c[3:0] + 4'd8;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sign_r  <= sign_nxt;
      zero_r  <= zero_nxt;
      sat_r   <= sat_nxt;
      sig_r   <= sig_nxt;
      shamt_r <= shamt_nxt;
    end
  end

  // Both sides scaled by 2^8: sig<<(sh+8) against mid<<8.
  logic [22:0] val_c;
  logic [22:0] thr_c;
  logic [2:0]  cnt_c;
  logic        tie_c;
  logic [2:0]  idx_c;

  always_comb begin
    val_c = {15'd0, sig_r} << shamt_r;
    cnt_c = 3'd0;
    tie_c = 1'b0;
    thr_c = '0;
    for (int j = 0; j < NUM_MID; j++) begin
      thr_c = {10'd0, MID_Q[j], 8'd0};
      if (val_c > thr_c) cnt_c = cnt_c + 3'd1;
      if (val_c == thr_c) tie_c = 1'b1;
    end
    // tie: cnt is the lower neighbor, round to even
    idx_c = (tie_c && cnt_c[0]) ? cnt_c + 3'd1 : cnt_c;
    if (sat_r) idx_c = IDX_MAX;
    if (zero_r) idx_c = IDX_ZERO;
    code = {sign_r, idx_c};
  end

endmodule
`default_nettype wire

/* sv/bfe2m1_merge.sv */
// Packs the lane codes into one byte and holds it in the output register.
`default_nettype none
module bfe2m1_merge
  import bfe2m1_pkg::*;
#(
  parameter int NCAST = CAST_LANES_MAX
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    s1_valid,
  input  wire logic [NCAST*CODE_W-1:0] codes,
  input  wire logic                    out_ready,
  output logic                         s1_adv,
  output logic                         out_valid,
  output logic      [OUT_W-1:0]        out_data
);

  logic             valid_r;
  logic [OUT_W-1:0] data_r, data_nxt;

  assign s1_adv   = s1_valid && (!valid_r || out_ready);
  assign data_nxt = OUT_W'(codes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_adv) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
    if (s1_adv) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

/* bench/tb_bf16_to_e2m1_scaled_cast.sv */
// Testbench for bf16_to_e2m1_scaled_cast: a stream driver and monitor checked against a local predictor.
module tb_bf16_to_e2m1_scaled_cast;
  import bfe2m1_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 50;      // no idling once this few items are left
  localparam int CYCLE_LIMIT  = 200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;       // value_low[15:0], value_high[31:16], block_scale[39:32]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;           // packed_codes[7:0]

  logic [IN_W-1:0]  pending_items[$];
  logic [OUT_W-1:0] expected_codes[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               src_gap = 0;
  int               sink_gap = 0;

  bf16_to_e2m1_scaled_cast dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Quotient is sig * 2^sh quarters with sh = exp - scale - 5.
  function automatic logic [CODE_W-1:0] e2m1_code(input logic [BF16_W-1:0] bf,
                                                  input logic [SCALE_W-1:0] scale);
    logic [14:0] mag;
    int          exp_f;
    int          sc;
    int          sh;
    int          sig;
    int          num;
    int          den_sh;
    int          idx;
    int          thr;
    bit          tie;
    int          mids[7];
    mids = '{1, 3, 5, 7, 10, 14, 20};
    mag = bf[14:0];
    if (mag[14:7] == 8'hFF) mag = 15'h7F7F;   // inf and nan clamp to max finite
    exp_f = mag[14:7];
    sc = scale;
    idx = 0;
    tie = 1'b0;
    if (exp_f != 0) begin
      sig = 128 + mag[6:0];
      sh = exp_f - sc - 5;
      if (sh >= 8) begin
        idx = 7;
      end else if (sh >= -8) begin
        if (sh >= 0) begin
          num = sig << sh;
          den_sh = 0;
        end else begin
          num = sig;
          den_sh = -sh;
        end
        for (int j = 0; j < 7; j++) begin
          thr = mids[j] << den_sh;
          if (num > thr) begin
            idx = j + 1;
          end else begin
            tie = (num == thr);
            break;
          end
        end
        if (tie && idx[0]) idx = idx + 1;
      end
    end
    return {bf[15], idx[2:0]};
  endfunction

  function automatic logic [OUT_W-1:0] packed_pair(input logic [IN_W-1:0] item);
    return {e2m1_code(item[31:16], item[39:32]), e2m1_code(item[15:0], item[39:32])};
  endfunction

  function automatic logic [IN_W-1:0] pack_item(input logic [15:0] lo, input logic [15:0] hi,
                                                input logic [7:0] scale);
    return {scale, hi, lo};
  endfunction

  // Mostly elements whose exponent sits near the scale, so the grid is exercised.
  function automatic logic [BF16_W-1:0] pick_elem(input logic [SCALE_W-1:0] scale);
    logic [BF16_W-1:0] v;
    int                r;
    int                e;
    v = BF16_W'($urandom);
    r = $urandom_range(0, 9);
    if (r < 7) begin
      e = int'(scale) + 5 + $urandom_range(0, 20) - 10;
      if (e < 0) e = 0;
      if (e > 255) e = 255;
      v[14:7] = e[7:0];
      // sparse mantissas land on tie points
      if ($urandom_range(0, 2) == 0) v[6:0] = {3'($urandom_range(0, 7)), 4'b0000};
    end else if (r == 7) begin
      v[14:7] = ($urandom_range(0, 1) == 1) ? BF16_EXP_ALL : 8'h00;
    end
    return v;
  endfunction

  initial begin
    logic [7:0] scale;
    // zeros, subnormals, inf, nan, max finite
    pending_items.push_back(pack_item(16'h0000, 16'h8000, 8'd127));
    pending_items.push_back(pack_item(16'h0001, 16'h807F, 8'd0));
    pending_items.push_back(pack_item(16'h7F80, 16'hFF80, 8'd127));
    pending_items.push_back(pack_item(16'h7FC1, 16'hFFFF, 8'd130));
    pending_items.push_back(pack_item(16'h7F7F, 16'hFF7F, 8'd255));
    pending_items.push_back(pack_item(16'h7F7F, 16'h0080, 8'd0));
    pending_items.push_back(pack_item(16'hFFFF, 16'h7FFF, 8'd255));
    pending_items.push_back(pack_item(16'h0080, 16'h8080, 8'd255));
    // exact ties between grid points at unit scale
    pending_items.push_back(pack_item(16'h3E80, 16'h3F40, 8'd127));
    pending_items.push_back(pack_item(16'h3FA0, 16'h3FE0, 8'd127));
    pending_items.push_back(pack_item(16'h4020, 16'h4060, 8'd127));
    pending_items.push_back(pack_item(16'h40A0, 16'hC0A0, 8'd127));
    pending_items.push_back(pack_item(16'hBE80, 16'hBF40, 8'd127));
    // grid points and saturation
    pending_items.push_back(pack_item(16'h3F80, 16'h40C0, 8'd127));
    pending_items.push_back(pack_item(16'h40D0, 16'h40E0, 8'd127));
    pending_items.push_back(pack_item(16'hC0E0, 16'h4700, 8'd127));
    // grid points and a tie under a shifted scale
    pending_items.push_back(pack_item(16'h4080, 16'h4140, 8'd129));
    pending_items.push_back(pack_item(16'h3D80, 16'h3DA0, 8'd125));
    // shift window edges
    pending_items.push_back(pack_item(16'h0680, 16'h0600, 8'd0));
    pending_items.push_back(pack_item(16'h7F00, 16'h7E80, 8'd255));
    pending_items.push_back(pack_item(16'h3C00, 16'h3C80, 8'd127));
    pending_items.push_back(pack_item(16'h3C7F, 16'h3E7F, 8'd127));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0:       scale = 8'd0;
        1:       scale = 8'd255;
        default: scale = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 4) == 0)
        pending_items.push_back(pack_item(16'($urandom), 16'($urandom), scale));
      else
        pending_items.push_back(pack_item(pick_elem(scale), pick_elem(scale), scale));
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_bf16_to_e2m1_scaled_cast passed");
    end else begin
      $display("tb_bf16_to_e2m1_scaled_cast failed");
    end
    $finish;
  end

  // Source: the prediction is taken when the transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_codes.push_back(packed_pair(in_tdata));
      if (src_gap > 0) begin
        src_gap = src_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_items.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink: check each accepted byte, then pick the next ready level.
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_codes.size() == 0) begin
          $error("packed_codes expected none got %h", out_tdata);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_codes.pop_front();
          if (out_tdata !== want) begin
            $error("packed_codes expected %h got %h", want, out_tdata);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        out_tready <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bf16_to_e2m1_scaled_cast failed");
      $finish;
    end
  end

endmodule

/* sim.f */
sv/bfe2m1_pkg.sv
sv/bfe2m1_lane.sv
sv/bfe2m1_merge.sv
sv/bf16_to_e2m1_scaled_cast.sv
bench/tb_bf16_to_e2m1_scaled_cast.sv
